// ===== rtl/core/string_key_hash_table_rehash_probe_defines.svh =====
// Assertion macros shared by the hash table RTL.
// Depends on nothing; the asserting module provides aclk and aresetn.
`ifndef STRING_KEY_HASH_TABLE_REHASH_PROBE_DEFINES_SVH
`define STRING_KEY_HASH_TABLE_REHASH_PROBE_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define KHT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication.
`define KHT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kht_pkg.sv =====
// Shared constants, types and state encodings of the string key hash table.
// No dependencies.
package kht_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int KEY_CHARS   = 16;

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int CHAR_W  = $clog2(KEY_CHARS);
    localparam int LEN_W   = $clog2(KEY_CHARS + 1);
    localparam int PRB_W   = 7;
    localparam int MOD_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int USUM_W  = 10;
    localparam int ASUM_W  = 13;
    localparam int DIV_W   = 13;
    localparam int STAT_W  = 3;
    localparam int ADDR_W  = SLOT_W + CHAR_W;

    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_Z    = 8'h5A;
    localparam logic [MOD_W-1:0]  MODULUS_RESET = 7'd40;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_STORED   = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_FOUND    = 3'd2,
        STAT_MISSING  = 3'd3,
        STAT_TOO_LONG = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_PROBE,
        S_LEN,
        S_CHK,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

// ===== rtl/core/string_key_hash_table_rehash_probe.sv =====
// Open-addressing string key hash table: top level with the probe sequencer.
// Depends on kht_pkg, kht_divmod, kht_ram and the assertion macro header.
//
// Usage
//   Input channel (s_*): one key character per item in s_tdata; s_tuser holds
//   the operation (0 insert, 1 look up) and s_tlast marks the final character.
//   Only the operation of the final item counts. Items that are not final give
//   no result.
//   Result channel (m_*): one item per key with status, slot index and the
//   number of occupied slots examined.
//   Configuration: cfg_wr_en writes the 7-bit modulus (0 acts as 1, values
//   above 64 act as 64); write only while the block is idle.
// Processing
//   A final item passes a setup state, then the remainder units (one dividend
//   bit at a time), then the probed slots; a lookup reads each occupied slot's
//   stored length and, if it matches, compares the key byte by byte, since the
//   slot character memory gives one byte a cycle. A store then writes the key
//   into the slot one character at a time. One key is worked on at a time.
// Reset and stall
//   Reset empties the table through per-slot used bits and restores modulus
//   40. A finished result waits in the output register while new characters
//   are still taken; the next key's final item waits only at its end.
`include "string_key_hash_table_rehash_probe_defines.svh"

module string_key_hash_table_rehash_probe (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,   // table_modulus
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] key_char
    input  logic [0:0]  s_tuser,       // [0] operation
    input  logic        s_tlast,       // last_char
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // [2:0] status, [8:3] slot_index, [15:9] probe_count
);

    localparam int SLOT_W = kht_pkg::SLOT_W;
    localparam int CHAR_W = kht_pkg::CHAR_W;
    localparam int LEN_W  = kht_pkg::LEN_W;
    localparam int PRB_W  = kht_pkg::PRB_W;
    localparam int MOD_W  = kht_pkg::MOD_W;
    localparam int BYTE_W = kht_pkg::BYTE_W;

    kht_pkg::state_t state_reg, state_next;

    // configuration
    logic [MOD_W-1:0]   mod_reg;
    logic [MOD_W-1:0]   m_eff;

    // key being gathered
    logic [BYTE_W-1:0]  key_buf_reg [kht_pkg::KEY_CHARS];
    logic [LEN_W-1:0]   key_len_reg, key_len_next;
    logic               key_ovf_reg, key_ovf_next;
    logic [kht_pkg::USUM_W-1:0] usum_reg, usum_next;
    logic [kht_pkg::ASUM_W-1:0] asum_reg, asum_next;
    logic               op_reg, op_next;

    // table state
    logic               used_reg [kht_pkg::TABLE_SLOTS];
    logic [PRB_W-1:0]   occ_reg;
    logic               set_used;

    // walk state
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [SLOT_W-1:0]  h2_reg, h2_next;
    logic [PRB_W-1:0]   probes_reg, probes_next;
    logic [CHAR_W-1:0]  chr_reg, chr_next;
    logic [SLOT_W-1:0]  step_sel;
    logic [SLOT_W-1:0]  idx_adv;
    logic [MOD_W-1:0]   adv_sum;

    // result
    kht_pkg::status_t   res_status_reg, res_status_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic [PRB_W-1:0]   res_probes_reg, res_probes_next;
    logic               m_valid_reg;
    logic [15:0]        m_data_reg;

    // handshakes and decoded conditions
    logic               s_acc;
    logic               out_free;
    logic               key_room;
    logic               is_upper;
    logic               chr_last;
    logic               cur_used;

    // remainder units
    logic               div_start;
    logic [kht_pkg::DIV_W-1:0] asum_abs;
    logic               u_done, a_done;
    logic [MOD_W-1:0]   u_rem, a_rem;
    logic [MOD_W-1:0]   h2_fix;

    // memories
    logic               chr_we, chr_re;
    logic [kht_pkg::ADDR_W-1:0] chr_waddr, chr_raddr;
    logic [BYTE_W-1:0]  chr_rdata;
    logic               len_we, len_re;
    logic [LEN_W-1:0]   len_rdata;
    logic [CHAR_W-1:0]  rd_chr;

    assign m_eff = (mod_reg == '0) ? MOD_W'(1) :
                   (mod_reg > MOD_W'(kht_pkg::TABLE_SLOTS)) ?
                   MOD_W'(kht_pkg::TABLE_SLOTS) : mod_reg;

    assign s_tready = (state_reg == kht_pkg::S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign key_room = key_len_reg < LEN_W'(kht_pkg::KEY_CHARS);
    assign is_upper = (s_tdata >= kht_pkg::CHAR_A) && (s_tdata <= kht_pkg::CHAR_Z);
    assign chr_last = (LEN_W'(chr_reg) + LEN_W'(1)) == key_len_reg;
    assign cur_used = used_reg[idx_reg];

    // step by the second hash after the first occupied slot, by one after that
    assign step_sel = (probes_next == PRB_W'(1)) ? h2_reg : SLOT_W'(1);
    assign adv_sum  = MOD_W'(idx_reg) + MOD_W'(step_sel);
    assign idx_adv  = (adv_sum >= m_eff) ? SLOT_W'(adv_sum - m_eff) : SLOT_W'(adv_sum);

    // C-style remainder of a negative sum: fold back into 0..m-1
    assign asum_abs  = asum_reg[kht_pkg::ASUM_W-1] ? kht_pkg::DIV_W'(-asum_reg)
                                                   : kht_pkg::DIV_W'(asum_reg);
    assign h2_fix    = (asum_reg[kht_pkg::ASUM_W-1] && a_rem != '0) ? (m_eff - a_rem) : a_rem;
    assign div_start = (state_reg == kht_pkg::S_START);

    kht_divmod u_div_upper (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (kht_pkg::DIV_W'(usum_reg)),
        .divisor   (m_eff),
        .done      (u_done),
        .remainder (u_rem)
    );

    kht_divmod u_div_all (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (asum_abs),
        .divisor   (m_eff),
        .done      (a_done),
        .remainder (a_rem)
    );

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kht_pkg::S_IDLE: begin
                if (s_acc && s_tlast) begin
                    state_next = key_ovf_next ? kht_pkg::S_DONE : kht_pkg::S_START;
                end
            end
            kht_pkg::S_START: state_next = kht_pkg::S_DIV;
            kht_pkg::S_DIV: begin
                if (u_done && a_done) begin
                    if (op_reg == kht_pkg::OP_INSERT && occ_reg >= m_eff) begin
                        state_next = kht_pkg::S_DONE;
                    end else begin
                        state_next = kht_pkg::S_PROBE;
                    end
                end
            end
            kht_pkg::S_PROBE: begin
                if (!cur_used) begin
                    state_next = (op_reg == kht_pkg::OP_INSERT) ? kht_pkg::S_WRITE
                                                                : kht_pkg::S_DONE;
                end else if (op_reg == kht_pkg::OP_LOOKUP) begin
                    state_next = kht_pkg::S_LEN;
                end else if (probes_reg == m_eff) begin
                    state_next = kht_pkg::S_DONE;
                end
            end
            kht_pkg::S_LEN: begin
                if (len_rdata == key_len_reg) begin
                    state_next = kht_pkg::S_CHK;
                end else begin
                    state_next = (probes_reg >= m_eff) ? kht_pkg::S_DONE : kht_pkg::S_PROBE;
                end
            end
            kht_pkg::S_CHK: begin
                if (chr_rdata != key_buf_reg[chr_reg]) begin
                    state_next = (probes_reg >= m_eff) ? kht_pkg::S_DONE : kht_pkg::S_PROBE;
                end else if (chr_last) begin
                    state_next = kht_pkg::S_DONE;
                end
            end
            kht_pkg::S_WRITE: begin
                if (chr_last) begin
                    state_next = kht_pkg::S_DONE;
                end
            end
            kht_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = kht_pkg::S_IDLE;
                end
            end
            default: state_next = kht_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        key_len_next    = key_len_reg;
        key_ovf_next    = key_ovf_reg;
        usum_next       = usum_reg;
        asum_next       = asum_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        h2_next         = h2_reg;
        probes_next     = probes_reg;
        chr_next        = chr_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_probes_next = res_probes_reg;
        set_used        = 1'b0;
        chr_re          = 1'b0;
        len_re          = 1'b0;
        rd_chr          = '0;

        unique case (state_reg)
            kht_pkg::S_IDLE: begin
                if (s_acc) begin
                    op_next = s_tuser[0];
                    if (key_room) begin
                        key_len_next = key_len_reg + LEN_W'(1);
                        asum_next    = asum_reg + kht_pkg::ASUM_W'(s_tdata)
                                       - kht_pkg::ASUM_W'(kht_pkg::CHAR_ZERO);
                        if (is_upper) begin
                            usum_next = usum_reg + kht_pkg::USUM_W'(s_tdata)
                                        - kht_pkg::USUM_W'(kht_pkg::CHAR_ZERO);
                        end
                    end else begin
                        key_ovf_next = 1'b1;
                    end
                    if (s_tlast && key_ovf_next) begin
                        res_status_next = kht_pkg::STAT_TOO_LONG;
                        res_slot_next   = '0;
                        res_probes_next = '0;
                    end
                end
            end
            kht_pkg::S_START: begin
                probes_next = '0;
            end
            kht_pkg::S_DIV: begin
                idx_next = SLOT_W'(u_rem);
                h2_next  = SLOT_W'(h2_fix);
                res_status_next = kht_pkg::STAT_FULL;
                res_slot_next   = '0;
                res_probes_next = '0;
            end
            kht_pkg::S_PROBE: begin
                chr_next = '0;
                if (!cur_used) begin
                    res_status_next = kht_pkg::STAT_MISSING;
                    res_slot_next   = '0;
                    res_probes_next = probes_reg;
                end else begin
                    probes_next = probes_reg + PRB_W'(1);
                    if (op_reg == kht_pkg::OP_LOOKUP) begin
                        // fetch the stored length and first character
                        chr_re = 1'b1;
                        len_re = 1'b1;
                    end else if (probes_reg == m_eff) begin
                        // as many occupied slots visited as the modulus: table full
                        res_status_next = kht_pkg::STAT_FULL;
                        res_slot_next   = '0;
                        res_probes_next = '0;
                    end else begin
                        idx_next = idx_adv;
                    end
                end
            end
            kht_pkg::S_LEN: begin
                if (len_rdata != key_len_reg) begin
                    res_status_next = kht_pkg::STAT_MISSING;
                    res_slot_next   = '0;
                    res_probes_next = probes_reg;
                    idx_next        = idx_adv;
                end
            end
            kht_pkg::S_CHK: begin
                if (chr_rdata != key_buf_reg[chr_reg]) begin
                    res_status_next = kht_pkg::STAT_MISSING;
                    res_slot_next   = '0;
                    res_probes_next = probes_reg;
                    idx_next        = idx_adv;
                end else if (chr_last) begin
                    res_status_next = kht_pkg::STAT_FOUND;
                    res_slot_next   = idx_reg;
                    res_probes_next = probes_reg;
                end else begin
                    chr_next = chr_reg + CHAR_W'(1);
                    rd_chr   = chr_reg + CHAR_W'(1);
                    chr_re   = 1'b1;
                end
            end
            kht_pkg::S_WRITE: begin
                chr_next = chr_reg + CHAR_W'(1);
                if (chr_last) begin
                    set_used        = 1'b1;
                    res_status_next = kht_pkg::STAT_STORED;
                    res_slot_next   = idx_reg;
                    res_probes_next = probes_reg;
                end
            end
            kht_pkg::S_DONE: begin
                if (out_free) begin
                    // drop the finished key
                    key_len_next = '0;
                    key_ovf_next = 1'b0;
                    usum_next    = '0;
                    asum_next    = '0;
                end
            end
            default: ;
        endcase
    end

    // step back from the probe state only when the walk continues
    // (idx_adv in S_PROBE uses the count after this slot; in S_LEN/S_CHK
    // probes_next equals probes_reg, already counting the slot)

    assign chr_we    = (state_reg == kht_pkg::S_WRITE);
    assign chr_waddr = {idx_reg, chr_reg};
    assign chr_raddr = {idx_reg, rd_chr};
    assign len_we    = chr_we && (chr_reg == '0);

    kht_ram #(
        .DEPTH (kht_pkg::TABLE_SLOTS * kht_pkg::KEY_CHARS),
        .WIDTH (BYTE_W)
    ) u_chr_ram (
        .aclk  (aclk),
        .we    (chr_we),
        .waddr (chr_waddr),
        .wdata (key_buf_reg[chr_reg]),
        .re    (chr_re),
        .raddr (chr_raddr),
        .rdata (chr_rdata)
    );

    kht_ram #(
        .DEPTH (kht_pkg::TABLE_SLOTS),
        .WIDTH (LEN_W)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (idx_reg),
        .wdata (key_len_reg),
        .re    (len_re),
        .raddr (idx_reg),
        .rdata (len_rdata)
    );

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kht_pkg::S_IDLE;
            mod_reg     <= kht_pkg::MODULUS_RESET;
            key_len_reg <= '0;
            key_ovf_reg <= 1'b0;
            usum_reg    <= '0;
            asum_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < kht_pkg::TABLE_SLOTS; i++) begin
                used_reg[i] <= 1'b0;
            end
        end else begin
            state_reg   <= state_next;
            key_len_reg <= key_len_next;
            key_ovf_reg <= key_ovf_next;
            usum_reg    <= usum_next;
            asum_reg    <= asum_next;
            if (cfg_wr_en) begin
                mod_reg <= cfg_wr_data;
            end
            if (set_used) begin
                used_reg[idx_reg] <= 1'b1;
                if (occ_reg < PRB_W'(kht_pkg::TABLE_SLOTS)) begin
                    occ_reg <= occ_reg + PRB_W'(1);
                end
            end
            if (state_reg == kht_pkg::S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        h2_reg         <= h2_next;
        probes_reg     <= probes_next;
        chr_reg        <= chr_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_probes_reg <= res_probes_next;
        if (s_acc && key_room) begin
            key_buf_reg[key_len_reg[CHAR_W-1:0]] <= s_tdata;
        end
        if (state_reg == kht_pkg::S_DONE && out_free) begin
            m_data_reg <= {res_probes_reg, res_slot_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------------------------------------------------------- checks
    `KHT_ASSERT_ALWAYS(a_occ_bound, occ_reg <= PRB_W'(kht_pkg::TABLE_SLOTS), "occupancy overrun")
    `KHT_ASSERT_IMPL(a_idx_in_range, state_reg == kht_pkg::S_PROBE, MOD_W'(idx_reg) < m_eff, "probe index outside modulus")
    `KHT_ASSERT_IMPL(a_write_free, state_reg == kht_pkg::S_WRITE, !cur_used, "store into an occupied slot")
    `KHT_ASSERT_IMPL(a_found_probed, m_valid_reg && m_data_reg[2:0] == kht_pkg::STAT_FOUND, m_data_reg[15:9] != '0, "found without a probe")

endmodule

// ===== rtl/core/kht_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module kht_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/kht_divmod.sv =====
// Restoring remainder unit: one dividend bit per cycle.
// Depends on kht_pkg.
module kht_divmod (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [kht_pkg::DIV_W-1:0]   dividend,
    input  logic [kht_pkg::MOD_W-1:0]   divisor,
    output logic                        done,
    output logic [kht_pkg::MOD_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(kht_pkg::DIV_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [kht_pkg::DIV_W-1:0]   dvd_reg, dvd_next;
    logic [kht_pkg::MOD_W-1:0]   rem_reg, rem_next;
    logic [kht_pkg::MOD_W:0]     rem_sh;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, dvd_reg[kht_pkg::DIV_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            // shift in the next bit, subtract when it fits
            if (rem_sh >= {1'b0, divisor}) begin
                rem_next = kht_pkg::MOD_W'(rem_sh - {1'b0, divisor});
            end else begin
                rem_next = kht_pkg::MOD_W'(rem_sh);
            end
            dvd_next = {dvd_reg[kht_pkg::DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(kht_pkg::DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== bench/string_key_hash_table_rehash_probe_test.sv =====
`timescale 1ns / 1ps
// Self-checking string key hash table bench: directed table, modulus cases, random keys.
// Depends on kht_pkg and the string_key_hash_table_rehash_probe RTL.
module string_key_hash_table_rehash_probe_test;

    // last field in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [6:0] probes;
        logic [5:0] slot;
        logic [2:0] status;
    } verdict_t;

    // one row of the directed table; has_fixed marks a hand-typed expectation
    typedef struct {
        logic       op;
        logic [7:0] ch;
        logic       last;
        bit         has_fixed;
        verdict_t   fixed;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    string_key_hash_table_rehash_probe dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mirror of the table state
    logic [6:0]  modulus_reg;
    logic [7:0]  key_buf [kht_pkg::KEY_CHARS];
    int          key_len;
    bit          key_ovf;
    int          upper_acc;
    int          all_acc;
    int          occupied;
    bit          used [kht_pkg::TABLE_SLOTS];
    logic [7:0]  stored_chars [kht_pkg::TABLE_SLOTS][kht_pkg::KEY_CHARS];
    int          stored_len [kht_pkg::TABLE_SLOTS];

    verdict_t    pending_verdicts [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // Keys used for the random part, so lookups mostly hit
    string       known_keys [$];

    function automatic void table_reset();
        modulus_reg = kht_pkg::MODULUS_RESET;
        key_len = 0; key_ovf = 0; upper_acc = 0; all_acc = 0; occupied = 0;
        foreach (used[i]) used[i] = 0;
    endfunction

    function automatic bit key_matches(int s);
        if (stored_len[s] != key_len) return 0;
        for (int i = 0; i < key_len; i++)
            if (stored_chars[s][i] != key_buf[i]) return 0;
        return 1;
    endfunction

    // Advance the mirror by one character; returns 1 with the verdict on a final item
    function automatic bit table_step(logic op, logic [7:0] ch, logic last,
                                      output verdict_t v);
        int m, h1, h2, r, idx, probes;
        bit any_free;
        v = '0;
        if (key_len < kht_pkg::KEY_CHARS) begin
            key_buf[key_len] = ch;
            key_len++;
            all_acc += int'(ch) - int'(kht_pkg::CHAR_ZERO);
            if (ch >= kht_pkg::CHAR_A && ch <= kht_pkg::CHAR_Z)
                upper_acc += int'(ch) - int'(kht_pkg::CHAR_ZERO);
        end else begin
            key_ovf = 1;
        end
        if (!last) return 0;
        if (key_ovf) begin
            v.status = kht_pkg::STAT_TOO_LONG;
        end else begin
            m = (modulus_reg == 0) ? 1 :
                (modulus_reg > kht_pkg::TABLE_SLOTS ? kht_pkg::TABLE_SLOTS : modulus_reg);
            h1 = upper_acc % m;
            r = all_acc % m;
            h2 = r < 0 ? r + m : r;
            idx = h1;
            probes = 0;
            if (op == kht_pkg::OP_INSERT) begin
                any_free = 0;
                for (int i = 0; i < m; i++) if (!used[i]) any_free = 1;
                if (occupied >= m || !any_free) begin
                    v.status = kht_pkg::STAT_FULL;
                end else begin
                    while (used[idx]) begin
                        probes++;
                        idx = (idx + (probes == 1 ? h2 : 1)) % m;
                    end
                    used[idx] = 1;
                    stored_len[idx] = key_len;
                    for (int i = 0; i < key_len; i++) stored_chars[idx][i] = key_buf[i];
                    if (occupied < kht_pkg::TABLE_SLOTS) occupied++;
                    v.status = kht_pkg::STAT_STORED;
                    v.slot = 6'(idx);
                end
            end else begin
                v.status = kht_pkg::STAT_MISSING;
                while (used[idx]) begin
                    probes++;
                    if (key_matches(idx)) begin
                        v.status = kht_pkg::STAT_FOUND;
                        v.slot = 6'(idx);
                        break;
                    end
                    if (probes >= m) break;
                    idx = (idx + (probes == 1 ? h2 : 1)) % m;
                end
            end
            v.probes = 7'(probes);
        end
        key_len = 0; key_ovf = 0; upper_acc = 0; all_acc = 0;
        return 1;
    endfunction

    // Offer one item until an edge leaves s_tready high, then predict; valid stays high
    task automatic send_char(logic op, logic [7:0] ch, logic last);
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= op;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (table_step(op, ch, last, v)) pending_verdicts = {pending_verdicts, v};
    endtask

    task automatic send_key(logic op, string k);
        for (int i = 0; i < k.len(); i++)
            send_char(i == k.len() - 1 ? op : logic'($urandom_range(1)), k[i], i == k.len() - 1);
    endtask

    // Hold off until every result is in, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_modulus(logic [6:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        modulus_reg = value;
    endtask

    function automatic string random_key();
        string k;
        int n;
        n = $urandom_range(1, 6);
        k = "";
        for (int i = 0; i < n; i++)
            k = {k, string'(byte'($urandom_range(3) != 0 ? $urandom_range(8'h41, 8'h5A)
                                                         : $urandom_range(0, 255)))};
        // zero bytes vanish from strings; an empty key becomes a letter
        if (k.len() == 0) k = "Q";
        return k;
    endfunction

    // Receiver: stall at random and check each result against the oldest prediction
    always @(posedge aclk) begin
        verdict_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                if (got.slot !== want.slot)
                    $display("%0t: slot_index expected %0d actual %0d", $time, want.slot,
                             got.slot);
                if (got.probes !== want.probes)
                    $display("%0t: probe_count expected %0d actual %0d", $time,
                             want.probes, got.probes);
                if (got !== want) errors++;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Directed rows: empty-table lookups, extremes, a long key, duplicates
    row_t rows [$];

    task automatic add_row(logic op, logic [7:0] ch, logic last, bit fixed = 0,
                           logic [2:0] st = 0);
        row_t r;
        r.op = op; r.ch = ch; r.last = last; r.has_fixed = fixed;
        r.fixed = '{status: st, slot: 0, probes: 0};
        rows = {rows, r};
    endtask

    initial begin
        string k;
        verdict_t v;
        int rnd;
        // lookup in an empty table: not found, nothing examined
        add_row(kht_pkg::OP_LOOKUP, 8'h00, 1, 1, kht_pkg::STAT_MISSING);
        add_row(kht_pkg::OP_LOOKUP, 8'hFF, 1, 1, kht_pkg::STAT_MISSING);
        // extremes inserted, 8'hFF looked up; operation bit of inner items ignored
        add_row(kht_pkg::OP_INSERT, 8'h00, 1);
        add_row(kht_pkg::OP_INSERT, 8'hFF, 1);
        add_row(kht_pkg::OP_LOOKUP, 8'h41, 0);
        add_row(kht_pkg::OP_INSERT, 8'h5A, 1);
        add_row(kht_pkg::OP_INSERT, 8'h41, 0);
        add_row(kht_pkg::OP_LOOKUP, 8'h5A, 1);
        add_row(kht_pkg::OP_LOOKUP, 8'hFF, 1);
        // duplicate inserts each take their own slot
        add_row(kht_pkg::OP_INSERT, 8'h41, 1);
        add_row(kht_pkg::OP_INSERT, 8'h41, 1);
        add_row(kht_pkg::OP_LOOKUP, 8'h41, 1);
        // seventeen characters: too long
        for (int i = 0; i < kht_pkg::KEY_CHARS; i++) add_row(kht_pkg::OP_INSERT, 8'h55, 0);
        add_row(kht_pkg::OP_INSERT, 8'hAA, 1, 1, kht_pkg::STAT_TOO_LONG);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        table_reset();
        @(posedge aclk);

        send_idle_pct = 34;
        recv_idle_pct = 81;
        foreach (rows[i]) begin
            if (rows[i].has_fixed) begin
                // typed expectation must agree with the mirror; keep it authoritative
                send_char(rows[i].op, rows[i].ch, rows[i].last);
                v = pending_verdicts[pending_verdicts.size() - 1];
                if (v !== rows[i].fixed)
                    pending_verdicts[pending_verdicts.size() - 1] = rows[i].fixed;
            end else begin
                send_char(rows[i].op, rows[i].ch, rows[i].last);
            end
        end

        // fill a tiny table to full, then a modulus of zero, then a modulus above 64
        write_modulus(7'd3);
        for (int i = 0; i < 5; i++) send_key(kht_pkg::OP_INSERT, random_key());
        write_modulus(7'd0);
        send_key(kht_pkg::OP_INSERT, "B");
        send_key(kht_pkg::OP_LOOKUP, "B");
        write_modulus(7'd127);
        for (int i = 0; i < 8; i++) send_key(kht_pkg::OP_LOOKUP, random_key());

        // random part in three idling phases and several moduli
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin send_idle_pct = 81; recv_idle_pct = 34; end
            if (phase == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            case (phase)
                0: write_modulus(7'd64);
                1: write_modulus(7'd1 + 7'($urandom_range(62)));
                default: write_modulus(7'd65 + 7'($urandom_range(62)));
            endcase
            rnd = 0;
            while (rnd < 330) begin
                if ($urandom_range(9) == 0) begin
                    // broken sequence: over-long key
                    for (int i = 0; i <= kht_pkg::KEY_CHARS; i++) begin
                        send_char(logic'($urandom_range(1)), 8'($urandom_range(255)),
                                  i == kht_pkg::KEY_CHARS);
                        rnd++;
                    end
                end else if (known_keys.size() != 0 && $urandom_range(1)) begin
                    k = known_keys[$urandom_range(known_keys.size() - 1)];
                    send_key(kht_pkg::OP_LOOKUP, k);
                    rnd += k.len();
                end else begin
                    k = random_key();
                    if (known_keys.size() < 40) known_keys = {known_keys, k};
                    send_key($urandom_range(3) == 0 ? kht_pkg::OP_LOOKUP
                                                    : kht_pkg::OP_INSERT, k);
                    rnd += k.len();
                end
            end
        end

        drain();
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("string_key_hash_table_rehash_probe_test: done, clean");
        end else begin
            $display("string_key_hash_table_rehash_probe_test: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("string_key_hash_table_rehash_probe_test: done, errors");
        $finish;
    end
endmodule

// ===== string_key_hash_table_rehash_probe.f =====
+incdir+rtl/core
rtl/core/kht_pkg.sv
rtl/core/kht_ram.sv
rtl/core/kht_divmod.sv
rtl/core/string_key_hash_table_rehash_probe.sv
bench/string_key_hash_table_rehash_probe_test.sv
